>>> rtl/etbg_pkg.sv
// Shared types and constants for the enveloped tone burst generator.
`timescale 1ns / 1ps
`default_nettype none

package etbg_pkg;

    localparam int DEFAULT_SINE_TABLE_DEPTH = 256;
    localparam int DEFAULT_SAMPLE_WIDTH     = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BEEP_SAMPLES = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_SAMPLES  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_SAMPLES = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BEEP_COUNT   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_SAMPLES = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEP    = 3'd7;

    localparam int PHASE_W = 32;
    localparam int AMP_W   = 15;
    localparam int LEN_W   = 16;
    localparam int COUNT_W = 4;
    localparam int RAMP_W  = 12;
    localparam int STEP_W  = 16;
    localparam int ENV_W   = 17;

    localparam logic [PHASE_W-1:0] RST_PHASE_STEP   = 32'd85704563;
    localparam logic [AMP_W-1:0]   RST_AMPLITUDE    = 15'd11469;
    localparam logic [LEN_W-1:0]   RST_BEEP_SAMPLES = 16'd7938;
    localparam logic [LEN_W-1:0]   RST_GAP_SAMPLES  = 16'd6174;
    localparam logic [LEN_W-1:0]   RST_TAIL_SAMPLES = 16'd39690;
    localparam logic [COUNT_W-1:0] RST_BEEP_COUNT   = 4'd2;
    localparam logic [RAMP_W-1:0]  RST_RAMP_SAMPLES = 12'd264;
    localparam logic [STEP_W-1:0]  RST_RAMP_STEP    = 16'd248;

    // Unity gain of the Q1.16 envelope
    localparam logic [ENV_W-1:0] ENV_UNITY = 17'd65536;

    // pi/2 in Q30, seed of the sine series
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        SEG_BEEP = 2'd0,
        SEG_GAP  = 2'd1,
        SEG_TAIL = 2'd2
    } seg_t;

endpackage

`default_nettype wire

>>> rtl/etbg_if.sv
// Valid/ready channel interfaces for the tone burst generator.
`timescale 1ns / 1ps
`default_nettype none

interface etbg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface etbg_out_if #(
    parameter int SAMPLE_WIDTH = etbg_pkg::DEFAULT_SAMPLE_WIDTH
);
    logic                     valid;
    logic                     ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    etbg_pkg::seg_t           segment_kind;
    logic                     pattern_end;

    modport source (output valid, output sample, output segment_kind, output pattern_end,
                    input ready);
    modport sink   (input valid, input sample, input segment_kind, input pattern_end,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/enveloped_tone_burst_generator.sv
// Looping beep pattern generator: enveloped sine bursts, one PCM sample per beat.
// Use: each beat on tick asks for the next sample of the pattern; restart set
// in that beat jumps back to the first beep, sample zero, phase zero, before
// the sample is made. Each tick beat yields exactly one beat on audio: the
// sample, its segment kind (beep, gap, tail) and a flag on the last sample of
// the pattern. The user writes registers on cfg_write/cfg_index/cfg_data only
// while no sample is in flight; the block itself does not enforce this.
// Path: the tick beat passes through the fetch, load-A, multiply-A, load-B,
// multiply-B and finish states into the output register, and tick is not
// taken again until then. The radix-4 serial multiplier takes nine steps for
// sine times amplitude and nine more for that product times the envelope.
// tick is taken again once the state machine is back in idle, even while a result
// still waits in the output register; if the receiver stalls, the finished
// sample holds in the datapath until that register drains.
// Reset loads the default register set and restarts the pattern at the first
// beep.
`timescale 1ns / 1ps
`default_nettype none

module enveloped_tone_burst_generator #(
    parameter int SINE_TABLE_DEPTH = etbg_pkg::DEFAULT_SINE_TABLE_DEPTH,
    parameter int SAMPLE_WIDTH     = etbg_pkg::DEFAULT_SAMPLE_WIDTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    etbg_in_if.sink                              tick,
    etbg_out_if.source                           audio,
    input  wire logic                            cfg_write,
    input  wire logic [etbg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [etbg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int QUARTER_LEN = SINE_TABLE_DEPTH / 4;
    localparam int QW          = $clog2(QUARTER_LEN);
    localparam int IDX_W       = QW + 2;
    localparam int MAG_W       = 15;
    localparam int MC_W        = 30;
    localparam int HI_W        = 32;
    localparam int LO_W        = 18;
    localparam int PROD_W      = HI_W + LO_W;
    localparam int MUL_STEPS   = LO_W / 2;
    localparam int STEP_CNT_W  = $clog2(MUL_STEPS);
    localparam int SHIFT       = 47 - SAMPLE_WIDTH;
    localparam int ENV_PROD_W  = etbg_pkg::RAMP_W + etbg_pkg::STEP_W;
    localparam logic [SAMPLE_WIDTH-1:0] LIMIT = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    // Quarter-wave sine magnitude, Q0.15, from a Q30 Taylor series
    function automatic logic [(QUARTER_LEN+1)*MAG_W-1:0] build_quarter_sine();
        logic [(QUARTER_LEN+1)*MAG_W-1:0] tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] entry;
        longint      sum;
        tbl = '0;
        for (int k = 0; k <= QUARTER_LEN; k++)
        begin
            x    = (etbg_pkg::HALF_PI_Q30 * 64'(k)) / 64'(QUARTER_LEN);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            entry = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            tbl[k*MAG_W +: MAG_W] = entry[MAG_W-1:0];
        end
        return tbl;
    endfunction

    localparam logic [(QUARTER_LEN+1)*MAG_W-1:0] QSINE = build_quarter_sine();

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD_A,
        ST_MUL_A,
        ST_LOAD_B,
        ST_MUL_B,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        ENV_RAMP,
        ENV_FLAT,
        ENV_MUTE
    } env_mode_t;

    // Configuration registers
    logic [etbg_pkg::PHASE_W-1:0] phase_step_reg;
    logic [etbg_pkg::AMP_W-1:0]   amplitude_reg;
    logic [etbg_pkg::LEN_W-1:0]   beep_samples_reg;
    logic [etbg_pkg::LEN_W-1:0]   gap_samples_reg;
    logic [etbg_pkg::LEN_W-1:0]   tail_samples_reg;
    logic [etbg_pkg::COUNT_W-1:0] beep_count_reg;
    logic [etbg_pkg::RAMP_W-1:0]  ramp_samples_reg;
    logic [etbg_pkg::STEP_W-1:0]  ramp_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= etbg_pkg::RST_PHASE_STEP;
            amplitude_reg    <= etbg_pkg::RST_AMPLITUDE;
            beep_samples_reg <= etbg_pkg::RST_BEEP_SAMPLES;
            gap_samples_reg  <= etbg_pkg::RST_GAP_SAMPLES;
            tail_samples_reg <= etbg_pkg::RST_TAIL_SAMPLES;
            beep_count_reg   <= etbg_pkg::RST_BEEP_COUNT;
            ramp_samples_reg <= etbg_pkg::RST_RAMP_SAMPLES;
            ramp_step_reg    <= etbg_pkg::RST_RAMP_STEP;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                etbg_pkg::REG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                etbg_pkg::REG_AMPLITUDE:    amplitude_reg    <= cfg_data[etbg_pkg::AMP_W-1:0];
                etbg_pkg::REG_BEEP_SAMPLES: beep_samples_reg <= cfg_data[etbg_pkg::LEN_W-1:0];
                etbg_pkg::REG_GAP_SAMPLES:  gap_samples_reg  <= cfg_data[etbg_pkg::LEN_W-1:0];
                etbg_pkg::REG_TAIL_SAMPLES: tail_samples_reg <= cfg_data[etbg_pkg::LEN_W-1:0];
                etbg_pkg::REG_BEEP_COUNT:   beep_count_reg   <= cfg_data[etbg_pkg::COUNT_W-1:0];
                etbg_pkg::REG_RAMP_SAMPLES: ramp_samples_reg <= cfg_data[etbg_pkg::RAMP_W-1:0];
                etbg_pkg::REG_RAMP_STEP:    ramp_step_reg    <= cfg_data[etbg_pkg::STEP_W-1:0];
                default:                    ramp_step_reg    <= ramp_step_reg;
            endcase
        end
    end

    // Pattern position and sample datapath
    state_t                        state_reg, state_next;
    etbg_pkg::seg_t                segment_reg, segment_next;
    logic [etbg_pkg::COUNT_W-1:0]  beep_index_reg, beep_index_next;
    logic [etbg_pkg::LEN_W-1:0]    pos_reg, pos_next;
    logic [etbg_pkg::PHASE_W-1:0]  phase_reg, phase_next;

    etbg_pkg::seg_t                kind_reg, kind_next;
    logic                          end_reg, end_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    env_mode_t                     env_mode_reg, env_mode_next;
    logic [etbg_pkg::RAMP_W-1:0]   ramp_n_reg, ramp_n_next;
    logic [MAG_W-1:0]              mag_reg, mag_next;
    logic                          neg_reg, neg_next;
    logic [etbg_pkg::ENV_W-1:0]    env_reg, env_next;
    logic [MC_W-1:0]               mcand_reg, mcand_next;
    logic [HI_W-1:0]               mcand3_reg, mcand3_next;
    logic [HI_W-1:0]               hi_reg, hi_next;
    logic [LO_W-1:0]               lo_reg, lo_next;
    logic [STEP_CNT_W-1:0]         step_reg, step_next;

    logic                          out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0]       out_sample_reg, out_sample_next;
    etbg_pkg::seg_t                out_kind_reg, out_kind_next;
    logic                          out_end_reg, out_end_next;

    // Combinational helpers
    logic                          accept;
    etbg_pkg::seg_t                cur_seg;
    logic [etbg_pkg::COUNT_W-1:0]  cur_bi;
    logic [etbg_pkg::LEN_W-1:0]    cur_pos;
    logic [etbg_pkg::PHASE_W-1:0]  cur_phase;
    logic [etbg_pkg::LEN_W-1:0]    beep_len;
    logic [etbg_pkg::COUNT_W-1:0]  count_eff;
    logic [etbg_pkg::LEN_W-1:0]    seg_len;
    logic [etbg_pkg::LEN_W:0]      pos_inc;
    logic                          seg_done;
    logic [etbg_pkg::COUNT_W:0]    bi_inc;
    etbg_pkg::seg_t                adv_seg;
    logic [etbg_pkg::COUNT_W-1:0]  adv_bi;
    logic                          adv_wrap;
    etbg_pkg::seg_t                gap_seg;
    logic [etbg_pkg::COUNT_W-1:0]  gap_bi;
    logic                          gap_wrap;
    logic [etbg_pkg::LEN_W-1:0]    tail_dist;
    logic [QW:0]                   tbl_index;
    logic [ENV_PROD_W-1:0]         env_prod;
    logic [HI_W-1:0]               addend;
    logic [HI_W-1:0]               acc_sum;
    logic [MC_W-1:0]               prod_a;
    logic [PROD_W-1:0]             prod_b;
    logic [PROD_W-1:0]             scaled;
    logic [SAMPLE_WIDTH-1:0]       clamped;
    logic                          out_free;

    assign accept     = tick.valid && tick.ready;
    assign tick.ready = (state_reg == ST_IDLE);
    assign out_free   = !out_valid_reg || audio.ready;

    assign audio.valid        = out_valid_reg;
    assign audio.sample       = out_sample_reg;
    assign audio.segment_kind = out_kind_reg;
    assign audio.pattern_end  = out_end_reg;

    // Current position, with restart applied
    always_comb
    begin
        cur_seg   = tick.restart ? etbg_pkg::SEG_BEEP : segment_reg;
        cur_bi    = tick.restart ? '0 : beep_index_reg;
        cur_pos   = tick.restart ? '0 : pos_reg;
        cur_phase = tick.restart ? '0 : phase_reg;

        beep_len  = (beep_samples_reg == '0) ? etbg_pkg::LEN_W'(1) : beep_samples_reg;
        count_eff = (beep_count_reg == '0) ? etbg_pkg::COUNT_W'(1) : beep_count_reg;

        case (cur_seg)
            etbg_pkg::SEG_BEEP: seg_len = beep_len;
            etbg_pkg::SEG_GAP:  seg_len = gap_samples_reg;
            default:            seg_len = tail_samples_reg;
        endcase

        pos_inc  = {1'b0, cur_pos} + 17'd1;
        seg_done = (pos_inc >= {1'b0, seg_len});
        bi_inc   = {1'b0, cur_bi} + 5'd1;

        // Leaving a gap: next beep, else the tail, else wrap (empty tail skipped)
        if (bi_inc < {1'b0, count_eff})
        begin
            gap_seg  = etbg_pkg::SEG_BEEP;
            gap_bi   = bi_inc[etbg_pkg::COUNT_W-1:0];
            gap_wrap = 1'b0;
        end
        else if (tail_samples_reg != '0)
        begin
            gap_seg  = etbg_pkg::SEG_TAIL;
            gap_bi   = cur_bi;
            gap_wrap = 1'b0;
        end
        else
        begin
            gap_seg  = etbg_pkg::SEG_BEEP;
            gap_bi   = '0;
            gap_wrap = 1'b1;
        end

        case (cur_seg)
            etbg_pkg::SEG_BEEP:
            begin
                if (gap_samples_reg != '0)
                begin
                    adv_seg  = etbg_pkg::SEG_GAP;
                    adv_bi   = cur_bi;
                    adv_wrap = 1'b0;
                end
                else
                begin
                    adv_seg  = gap_seg;
                    adv_bi   = gap_bi;
                    adv_wrap = gap_wrap;
                end
            end
            etbg_pkg::SEG_GAP:
            begin
                adv_seg  = gap_seg;
                adv_bi   = gap_bi;
                adv_wrap = gap_wrap;
            end
            default:
            begin
                adv_seg  = etbg_pkg::SEG_BEEP;
                adv_bi   = '0;
                adv_wrap = 1'b1;
            end
        endcase

        tail_dist = beep_len - cur_pos;
    end

    // Radix-4 serial multiplier step and result shaping
    always_comb
    begin
        case (lo_reg[1:0])
            2'd0:    addend = '0;
            2'd1:    addend = {2'b00, mcand_reg};
            2'd2:    addend = {1'b0, mcand_reg, 1'b0};
            2'd3:    addend = mcand3_reg;
            default: addend = '0;
        endcase
        acc_sum = hi_reg + addend;

        prod_a  = {hi_reg[MC_W-LO_W-1:0], lo_reg};
        prod_b  = {hi_reg, lo_reg};
        scaled  = prod_b >> SHIFT;
        clamped = (scaled > PROD_W'(LIMIT)) ? LIMIT : scaled[SAMPLE_WIDTH-1:0];

        tbl_index = idx_reg[QW] ? ((QW+1)'(QUARTER_LEN) - {1'b0, idx_reg[QW-1:0]})
                                : {1'b0, idx_reg[QW-1:0]};
        env_prod  = ramp_n_reg * ramp_step_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        segment_next    = segment_reg;
        beep_index_next = beep_index_reg;
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        end_next        = end_reg;
        idx_next        = idx_reg;
        env_mode_next   = env_mode_reg;
        ramp_n_next     = ramp_n_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        env_next        = env_reg;
        mcand_next      = mcand_reg;
        mcand3_next     = mcand3_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_kind_next   = out_kind_reg;
        out_end_next    = out_end_reg;

        if (audio.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = cur_seg;
                    end_next  = seg_done && adv_wrap;
                    idx_next  = cur_phase[etbg_pkg::PHASE_W-1 -: IDX_W];

                    // Pick the envelope region for this position
                    if (cur_pos < {4'b0, ramp_samples_reg})
                    begin
                        env_mode_next = ENV_RAMP;
                        ramp_n_next   = cur_pos[etbg_pkg::RAMP_W-1:0];
                    end
                    else if (({1'b0, cur_pos} + {5'b0, ramp_samples_reg}) > {1'b0, beep_len})
                    begin
                        env_mode_next = (cur_pos >= beep_len) ? ENV_MUTE : ENV_RAMP;
                        ramp_n_next   = tail_dist[etbg_pkg::RAMP_W-1:0];
                    end
                    else
                    begin
                        env_mode_next = ENV_FLAT;
                    end

                    if (seg_done)
                    begin
                        segment_next    = adv_seg;
                        beep_index_next = adv_bi;
                        pos_next        = '0;
                        phase_next      = '0;
                    end
                    else
                    begin
                        segment_next    = cur_seg;
                        beep_index_next = cur_bi;
                        pos_next        = pos_inc[etbg_pkg::LEN_W-1:0];
                        phase_next      = cur_phase + phase_step_reg;
                    end
                    state_next = ST_FETCH;
                end
            end

            ST_FETCH:
            begin
                mag_next = (kind_reg == etbg_pkg::SEG_BEEP) ? QSINE[tbl_index*MAG_W +: MAG_W]
                                                            : '0;
                neg_next = idx_reg[QW+1];
                case (env_mode_reg)
                    ENV_RAMP:
                        env_next = (env_prod > ENV_PROD_W'(etbg_pkg::ENV_UNITY))
                                 ? etbg_pkg::ENV_UNITY : env_prod[etbg_pkg::ENV_W-1:0];
                    ENV_FLAT: env_next = etbg_pkg::ENV_UNITY;
                    default:  env_next = '0;
                endcase
                state_next = ST_LOAD_A;
            end

            ST_LOAD_A:
            begin
                mcand_next  = {{(MC_W-MAG_W){1'b0}}, mag_reg};
                mcand3_next = {{(HI_W-MAG_W){1'b0}}, mag_reg}
                            + {{(HI_W-MAG_W-1){1'b0}}, mag_reg, 1'b0};
                hi_next     = '0;
                lo_next     = {{(LO_W-etbg_pkg::AMP_W){1'b0}}, amplitude_reg};
                step_next   = '0;
                state_next  = ST_MUL_A;
            end

            ST_MUL_A, ST_MUL_B:
            begin
                // Add one digit's multiple at the top, shift the pair right by a digit
                hi_next   = {2'b00, acc_sum[HI_W-1:2]};
                lo_next   = {acc_sum[1:0], lo_reg[LO_W-1:2]};
                step_next = step_reg + STEP_CNT_W'(1);
                if (step_reg == STEP_CNT_W'(MUL_STEPS - 1))
                    state_next = (state_reg == ST_MUL_A) ? ST_LOAD_B : ST_FINISH;
            end

            ST_LOAD_B:
            begin
                mcand_next  = prod_a;
                mcand3_next = {2'b00, prod_a} + {1'b0, prod_a, 1'b0};
                hi_next     = '0;
                lo_next     = {{(LO_W-etbg_pkg::ENV_W){1'b0}}, env_reg};
                step_next   = '0;
                state_next  = ST_MUL_B;
            end

            ST_FINISH:
            begin
                // Hold the finished sample until the output register drains
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = neg_reg ? (~clamped + SAMPLE_WIDTH'(1)) : clamped;
                    out_kind_next   = kind_reg;
                    out_end_next    = end_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            segment_reg    <= etbg_pkg::SEG_BEEP;
            beep_index_reg <= '0;
            pos_reg        <= '0;
            phase_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            segment_reg    <= segment_next;
            beep_index_reg <= beep_index_next;
            pos_reg        <= pos_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        end_reg        <= end_next;
        idx_reg        <= idx_next;
        env_mode_reg   <= env_mode_next;
        ramp_n_reg     <= ramp_n_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        env_reg        <= env_next;
        mcand_reg      <= mcand_next;
        mcand3_reg     <= mcand3_next;
        hi_reg         <= hi_next;
        lo_reg         <= lo_next;
        step_reg       <= step_next;
        out_sample_reg <= out_sample_next;
        out_kind_reg   <= out_kind_next;
        out_end_reg    <= out_end_next;
    end

endmodule

`default_nettype wire

>>> verif/tb_enveloped_tone_burst_generator.sv
// Self-checking testbench for the enveloped tone burst generator.
`timescale 1ns / 1ps

module tb_enveloped_tone_burst_generator;

    localparam int TABLE_DEPTH  = etbg_pkg::DEFAULT_SINE_TABLE_DEPTH;
    localparam int SAMPLE_W     = etbg_pkg::DEFAULT_SAMPLE_WIDTH;
    localparam int QUARTER      = TABLE_DEPTH / 4;
    localparam int PEAK         = (1 << (SAMPLE_W - 1)) - 1;
    localparam int RANDOM_TICKS = 1800;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_PRINTED  = 50;

    typedef longint unsigned u64_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] pcm;
        etbg_pkg::seg_t             kind;
        logic                       at_end;
    } tone_sample_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [etbg_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [etbg_pkg::CFG_DATA_W-1:0]  cfg_data;

    etbg_in_if                                tick_if ();
    etbg_out_if #(.SAMPLE_WIDTH(SAMPLE_W))    audio_if ();

    enveloped_tone_burst_generator #(
        .SINE_TABLE_DEPTH(TABLE_DEPTH),
        .SAMPLE_WIDTH(SAMPLE_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .tick(tick_if),
        .audio(audio_if),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Register shadows
    logic [etbg_pkg::PHASE_W-1:0] r_phase_step = etbg_pkg::RST_PHASE_STEP;
    logic [etbg_pkg::AMP_W-1:0]   r_amplitude  = etbg_pkg::RST_AMPLITUDE;
    logic [etbg_pkg::LEN_W-1:0]   r_beep_len   = etbg_pkg::RST_BEEP_SAMPLES;
    logic [etbg_pkg::LEN_W-1:0]   r_gap_len    = etbg_pkg::RST_GAP_SAMPLES;
    logic [etbg_pkg::LEN_W-1:0]   r_tail_len   = etbg_pkg::RST_TAIL_SAMPLES;
    logic [etbg_pkg::COUNT_W-1:0] r_beep_count = etbg_pkg::RST_BEEP_COUNT;
    logic [etbg_pkg::RAMP_W-1:0]  r_ramp_len   = etbg_pkg::RST_RAMP_SAMPLES;
    logic [etbg_pkg::STEP_W-1:0]  r_ramp_step  = etbg_pkg::RST_RAMP_STEP;

    // Pattern position
    etbg_pkg::seg_t               pat_seg   = etbg_pkg::SEG_BEEP;
    logic [etbg_pkg::COUNT_W-1:0] pat_beep  = '0;
    logic [etbg_pkg::LEN_W-1:0]   pat_pos   = '0;
    logic [etbg_pkg::PHASE_W-1:0] pat_phase = '0;

    int           quarter_sine [0:QUARTER];
    tone_sample_t samples_due [$];
    int           error_count = 0;
    int           ticks_sent  = 0;

    function automatic void build_quarter_sine();
        u64_t   x;
        u64_t   x2;
        u64_t   term;
        longint sum;
        for (int k = 0; k <= QUARTER; k++)
        begin
            x    = (u64_t'(etbg_pkg::HALF_PI_Q30) * k) / QUARTER;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum -= longint'(term);
                else
                    sum += longint'(term);
            end
            if (sum < 0)
                sum = 0;
            quarter_sine[k] = int'((u64_t'(sum) * 32767 + (u64_t'(1) << 29)) >> 30);
        end
    endfunction

    function automatic int sine_of(logic [etbg_pkg::PHASE_W-1:0] ph);
        int unsigned idx;
        int unsigned quad;
        int unsigned off;
        int          v;
        idx  = int'((u64_t'(ph) * TABLE_DEPTH) >> 32);
        quad = (idx / QUARTER) % 4;
        off  = idx % QUARTER;
        v    = (quad % 2 == 1) ? quarter_sine[QUARTER - off] : quarter_sine[off];
        return (quad >= 2) ? -v : v;
    endfunction

    function automatic int unsigned beep_length();
        return (r_beep_len == 0) ? 1 : r_beep_len;
    endfunction

    function automatic int unsigned seg_length(etbg_pkg::seg_t s);
        if (s == etbg_pkg::SEG_BEEP)
            return beep_length();
        if (s == etbg_pkg::SEG_GAP)
            return r_gap_len;
        return r_tail_len;
    endfunction

    function automatic u64_t envelope_gain(int unsigned i, int unsigned len);
        u64_t e;
        if (i < r_ramp_len)
            e = u64_t'(i) * r_ramp_step;
        else if (u64_t'(i) + r_ramp_len > len)
            e = (i >= len) ? 0 : u64_t'(len - i) * r_ramp_step;
        else
            e = etbg_pkg::ENV_UNITY;
        return (e > etbg_pkg::ENV_UNITY) ? u64_t'(etbg_pkg::ENV_UNITY) : e;
    endfunction

    // Step to the next non-empty segment; returns 1 when the pattern wraps.
    function automatic bit next_segment();
        bit          wrapped;
        int unsigned beeps;
        wrapped = 1'b0;
        beeps   = (r_beep_count == 0) ? 1 : r_beep_count;
        do
        begin
            case (pat_seg)
                etbg_pkg::SEG_BEEP: pat_seg = etbg_pkg::SEG_GAP;
                etbg_pkg::SEG_GAP:
                begin
                    if (pat_beep + 1 < beeps)
                    begin
                        pat_beep = pat_beep + etbg_pkg::COUNT_W'(1);
                        pat_seg  = etbg_pkg::SEG_BEEP;
                    end
                    else
                        pat_seg = etbg_pkg::SEG_TAIL;
                end
                default:
                begin
                    pat_seg  = etbg_pkg::SEG_BEEP;
                    pat_beep = '0;
                    wrapped  = 1'b1;
                end
            endcase
        end
        while (seg_length(pat_seg) == 0);
        pat_pos   = '0;
        pat_phase = '0;
        return wrapped;
    endfunction

    task automatic predict_sample(input logic restart);
        tone_sample_t want;
        int           s;
        u64_t         mag;
        int           level;
        if (restart)
        begin
            pat_seg   = etbg_pkg::SEG_BEEP;
            pat_beep  = '0;
            pat_pos   = '0;
            pat_phase = '0;
        end
        want.kind   = pat_seg;
        want.pcm    = '0;
        want.at_end = 1'b0;
        if (pat_seg == etbg_pkg::SEG_BEEP)
        begin
            s     = sine_of(pat_phase);
            mag   = u64_t'((s < 0) ? -s : s);
            mag   = (mag * r_amplitude * envelope_gain(pat_pos, beep_length()))
                    >> (47 - SAMPLE_W);
            level = (mag > PEAK) ? PEAK : int'(mag);
            want.pcm = SAMPLE_W'((s < 0) ? -level : level);
        end
        if (pat_pos + 1 >= seg_length(pat_seg))
            want.at_end = next_segment();
        else
        begin
            pat_pos   = pat_pos + etbg_pkg::LEN_W'(1);
            pat_phase = pat_phase + r_phase_step;
        end
        samples_due.push_back(want);
    endtask

    task automatic flag_error(input string what);
        if (error_count < MAX_PRINTED)
            $display("%0t: %s", $time, what);
        error_count++;
    endtask

    // Hold valid until the beat is taken, then predict it.
    task automatic send_tick(input logic restart);
        tick_if.valid   <= 1'b1;
        tick_if.restart <= restart;
        @(posedge clk);
        while (!tick_if.ready)
            @(posedge clk);
        predict_sample(restart);
        ticks_sent++;
    endtask

    task automatic end_burst();
        tick_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (samples_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [etbg_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [etbg_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            etbg_pkg::REG_PHASE_STEP:   r_phase_step = data[etbg_pkg::PHASE_W-1:0];
            etbg_pkg::REG_AMPLITUDE:    r_amplitude  = data[etbg_pkg::AMP_W-1:0];
            etbg_pkg::REG_BEEP_SAMPLES: r_beep_len   = data[etbg_pkg::LEN_W-1:0];
            etbg_pkg::REG_GAP_SAMPLES:  r_gap_len    = data[etbg_pkg::LEN_W-1:0];
            etbg_pkg::REG_TAIL_SAMPLES: r_tail_len   = data[etbg_pkg::LEN_W-1:0];
            etbg_pkg::REG_BEEP_COUNT:   r_beep_count = data[etbg_pkg::COUNT_W-1:0];
            etbg_pkg::REG_RAMP_SAMPLES: r_ramp_len   = data[etbg_pkg::RAMP_W-1:0];
            default:                    r_ramp_step  = data[etbg_pkg::STEP_W-1:0];
        endcase
        @(posedge clk);
    endtask

    task automatic write_pattern(input logic [etbg_pkg::CFG_DATA_W-1:0] beep,
                                 input logic [etbg_pkg::CFG_DATA_W-1:0] gap,
                                 input logic [etbg_pkg::CFG_DATA_W-1:0] tail,
                                 input logic [etbg_pkg::CFG_DATA_W-1:0] count);
        write_reg(etbg_pkg::REG_BEEP_SAMPLES, beep);
        write_reg(etbg_pkg::REG_GAP_SAMPLES, gap);
        write_reg(etbg_pkg::REG_TAIL_SAMPLES, tail);
        write_reg(etbg_pkg::REG_BEEP_COUNT, count);
    endtask

    // Mostly short values, now and then an end of the range.
    function automatic int unsigned pick_field(int unsigned top, int unsigned lo,
                                               int unsigned hi);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r == 1)
            return top;
        return $urandom_range(lo, hi);
    endfunction

    // Fill the bits above a register's width with noise.
    function automatic logic [etbg_pkg::CFG_DATA_W-1:0] noisy(int width, int unsigned v);
        return (etbg_pkg::CFG_DATA_W'($urandom()) << width) | etbg_pkg::CFG_DATA_W'(v);
    endfunction

    task automatic run_ticks(input int count, input int restart_permille);
        int burst_left;
        burst_left = $urandom_range(1, 40);
        for (int k = 0; k < count; k++)
        begin
            if (burst_left == 0)
            begin
                tick_if.valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
                if ($urandom_range(0, 19) == 0)
                    wait_drained();
                burst_left = $urandom_range(1, 40);
            end
            send_tick($urandom_range(0, 999) < restart_permille);
            burst_left--;
        end
        end_burst();
    endtask

    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        end_burst();
    endtask

    // Quarter turns per sample hit zero, both peaks and the table ends.
    task automatic test_quarter_turns();
        wait_drained();
        write_reg(etbg_pkg::REG_PHASE_STEP, 32'h4000_0000);
        write_reg(etbg_pkg::REG_AMPLITUDE, 32'd32767);
        write_reg(etbg_pkg::REG_RAMP_SAMPLES, 32'd1);
        write_reg(etbg_pkg::REG_RAMP_STEP, 32'd65535);
        write_pattern(32'd6, 32'd1, 32'd0, 32'd1);
        send_tick(1'b1);
        repeat (6) send_tick(1'b0);
        end_burst();
    endtask

    // Zero beep length and zero count act as one; empty gap and tail are skipped.
    task automatic test_degenerate_lengths();
        wait_drained();
        write_reg(etbg_pkg::REG_RAMP_SAMPLES, 32'd0);
        write_reg(etbg_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
        write_pattern(32'd0, 32'd0, 32'd0, 32'd0);
        repeat (3) send_tick(1'b0);
        end_burst();
    endtask

    // Shrink the beep below the current position: it ends after the next sample.
    task automatic test_shrunk_beep();
        wait_drained();
        write_reg(etbg_pkg::REG_PHASE_STEP, 32'h0123_4567);
        write_reg(etbg_pkg::REG_RAMP_SAMPLES, 32'd4);
        write_reg(etbg_pkg::REG_RAMP_STEP, 32'd16384);
        write_pattern(32'd20, 32'd2, 32'd1, 32'd1);
        send_tick(1'b1);
        repeat (7) send_tick(1'b0);
        end_burst();
        wait_drained();
        write_reg(etbg_pkg::REG_BEEP_SAMPLES, 32'd5);
        repeat (4) send_tick(1'b0);
        end_burst();
    endtask

    // Drop the count to the running beep index: its gap leads to the tail.
    task automatic test_count_cut();
        wait_drained();
        write_pattern(32'd1, 32'd1, 32'd2, 32'd3);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        end_burst();
        wait_drained();
        write_reg(etbg_pkg::REG_BEEP_COUNT, 32'd2);
        repeat (4) send_tick(1'b0);
        end_burst();
    endtask

    task automatic test_random_patterns();
        int done;
        int n;
        int restart_permille;
        done = 0;
        while (done < RANDOM_TICKS)
        begin
            wait_drained();
            if ($urandom_range(0, 3) != 0)
                write_reg(etbg_pkg::REG_PHASE_STEP, ($urandom_range(0, 9) == 0) ?
                          32'hFFFF_FFFF : $urandom());
            if ($urandom_range(0, 3) != 0)
                write_reg(etbg_pkg::REG_AMPLITUDE,
                          noisy(etbg_pkg::AMP_W, pick_field(32767, 0, 32767)));
            if ($urandom_range(0, 3) != 0)
                write_reg(etbg_pkg::REG_BEEP_SAMPLES,
                          noisy(etbg_pkg::LEN_W, pick_field(65535, 1, 24)));
            if ($urandom_range(0, 3) != 0)
                write_reg(etbg_pkg::REG_GAP_SAMPLES,
                          noisy(etbg_pkg::LEN_W, pick_field(65535, 0, 6)));
            if ($urandom_range(0, 3) != 0)
                write_reg(etbg_pkg::REG_TAIL_SAMPLES,
                          noisy(etbg_pkg::LEN_W, pick_field(65535, 0, 8)));
            if ($urandom_range(0, 3) != 0)
                write_reg(etbg_pkg::REG_BEEP_COUNT,
                          noisy(etbg_pkg::COUNT_W, pick_field(15, 1, 4)));
            if ($urandom_range(0, 3) != 0)
                write_reg(etbg_pkg::REG_RAMP_SAMPLES,
                          noisy(etbg_pkg::RAMP_W, pick_field(4095, 1, 10)));
            if ($urandom_range(0, 3) != 0)
                write_reg(etbg_pkg::REG_RAMP_STEP,
                          noisy(etbg_pkg::STEP_W, pick_field(65535, 0, 65535)));
            case ($urandom_range(0, 2))
                0:       restart_permille = 0;
                1:       restart_permille = 10;
                default: restart_permille = 60;
            endcase
            n = $urandom_range(20, 120);
            run_ticks(n, restart_permille);
            done += n;
        end
    endtask

    // Check each sample beat; the receiver alternates ready runs and stalls.
    initial
    begin : sample_checker
        tone_sample_t want;
        int           run_left;
        bit           level;
        audio_if.ready <= 1'b0;
        run_left = 0;
        level    = 1'b1;
        forever
        begin
            @(posedge clk);
            if (rst_n && audio_if.valid && audio_if.ready)
            begin
                if (samples_due.size() == 0)
                    flag_error("sample beat with nothing outstanding");
                else
                begin
                    want = samples_due.pop_front();
                    if (audio_if.sample !== want.pcm)
                        flag_error($sformatf("sample %0d, want %0d",
                                             audio_if.sample, want.pcm));
                    if (audio_if.segment_kind !== want.kind)
                        flag_error($sformatf("segment_kind %0d, want %0d",
                                             audio_if.segment_kind, want.kind));
                    if (audio_if.pattern_end !== want.at_end)
                        flag_error($sformatf("pattern_end %0b, want %0b",
                                             audio_if.pattern_end, want.at_end));
                end
            end
            if (run_left == 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        level    = 1'b1;
                        run_left = $urandom_range(100, 400);
                    end
                    2, 3, 4, 5:
                    begin
                        level    = 1'b1;
                        run_left = $urandom_range(1, 12);
                    end
                    default:
                    begin
                        level    = 1'b0;
                        run_left = $urandom_range(1, 15);
                    end
                endcase
            end
            run_left--;
            audio_if.ready <= level;
        end
    end

    // Give up when no beat moves on either channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((tick_if.valid && tick_if.ready) || (audio_if.valid && audio_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_enveloped_tone_burst_generator: errors");
        $finish;
    end

    initial
    begin
        rst_n           <= 1'b0;
        tick_if.valid   <= 1'b0;
        tick_if.restart <= 1'b0;
        cfg_write       <= 1'b0;
        cfg_index       <= etbg_pkg::REG_PHASE_STEP;
        cfg_data        <= '0;
        build_quarter_sine();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_quarter_turns();
        test_degenerate_lengths();
        test_shrunk_beep();
        test_count_cut();
        test_random_patterns();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_enveloped_tone_burst_generator: clean");
        else
            $display("tb_enveloped_tone_burst_generator: errors");
        $finish;
    end

endmodule
